FILE: rtl/md5_pkg.sv
package md5_pkg;

  // Standard initial chaining values.
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Padding marker byte and the last word position inside a block.
  localparam logic [7:0] PAD_BYTE      = 8'h80;
  localparam logic [3:0] LEN_LO_WORD   = 4'd14;
  localparam logic [3:0] LAST_WORD_IDX = 4'd15;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [2:0] FULL_COUNT    = 3'd4;
  localparam logic [1:0] LAST_DIGEST   = 2'd3;

  typedef logic [3:0][31:0] word4_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_item;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_OUT
  } state_t;

  // Status of the compression unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } cmp_status_t;

  // Additive constant of each round.
  function automatic logic [31:0] round_const(input logic [5:0] rnd);
    logic [31:0] k;
    unique case (rnd)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left rotate amount: four per quarter, repeating within a quarter.
  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    logic [4:0] s;
    unique case ({rnd[5:4], rnd[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by each round; the quarter selects the formula, which
  // works on the low four bits of the round number modulo sixteen.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] g;
    r = rnd[3:0];
    unique case (rnd[5:4])
      2'd0:    g = r;
      2'd1:    g = (r * 4'd5) + 4'd1;
      2'd2:    g = (r * 4'd3) + 4'd5;
      default: g = r * 4'd7;
    endcase
    return g;
  endfunction

  // Nonlinear round function of each quarter.
  function automatic logic [31:0] round_fn(input logic [5:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/md5_compress.sv
module md5_compress (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  md5_pkg::word4_t      chain_in,
  input  logic [31:0]          m_word,
  output logic [3:0]           rd_idx,
  output md5_pkg::cmp_status_t stat,
  output md5_pkg::word4_t      result
);

  logic        running;
  logic        done;
  logic [5:0]  round;
  logic [31:0] a, b, c, d;
  logic [31:0] km;
  logic [5:0]  next_round;
  logic [31:0] f_val;
  logic [31:0] sum;
  logic [4:0]  shamt;
  logic [31:0] rotated;

  // The round after this one selects the message word fetched now, so the
  // constant plus message word for that round is registered before it begins.
  assign next_round = start ? 6'd0 : round + 6'd1;
  assign rd_idx     = md5_pkg::msg_index(next_round);

  // One round of the shared datapath.
  always_comb begin
    f_val   = md5_pkg::round_fn(round, b, c, d);
    sum     = a + f_val + km;
    shamt   = md5_pkg::rot_amount(round);
    rotated = (sum << shamt) | (sum >> (6'd32 - {1'b0, shamt}));
  end

  // Round counter and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      round   <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        round   <= 6'd0;
        a       <= chain_in[0];
        b       <= chain_in[1];
        c       <= chain_in[2];
        d       <= chain_in[3];
        km      <= md5_pkg::round_const(next_round) + m_word;
      end else if (running) begin
        a     <= d;
        b     <= b + rotated;
        c     <= b;
        d     <= c;
        km    <= md5_pkg::round_const(next_round) + m_word;
        round <= next_round;
        if (round == md5_pkg::LAST_ROUND) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = running;
  assign stat.done = done;
  assign result    = {d, c, b, a};

  // A new block is never started while rounds are still in flight.
  assert property (@(posedge clk) disable iff (rst) start |-> !running)
    else $error("compression started while busy");

  // Completion follows the final round directly.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(running) && $past(round) == md5_pkg::LAST_ROUND))
    else $error("done without a final round");

  // Rounds advance one per cycle without gaps.
  assert property (@(posedge clk) disable iff (rst)
    (running && round != md5_pkg::LAST_ROUND) |=> (running && round == $past(round) + 6'd1))
    else $error("round counter skipped");

endmodule

FILE: rtl/md5_hash_engine.sv
// A word that does not complete a block is taken while the engine is idle. A word
// that completes a block starts the single round unit, which runs its 64 rounds;
// the unit then reports completion and the result folds into the chain.
// The engine takes no new word while a block is being padded or compressed.
// A last word adds up to 2 padded blocks, then four digest transactions.
// Reset (synchronous, active high) restores the initial chain, zero length and fill.
module md5_hash_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  md5_pkg::in_item_t   item,
  output logic                result_valid,
  input  logic                result_ready,
  output md5_pkg::out_item_t  result
);

  md5_pkg::state_t      state, state_next;
  md5_pkg::word4_t      chain;
  md5_pkg::word4_t      cmp_result;
  md5_pkg::cmp_status_t cmp_stat;
  logic [31:0]          blk [16];
  logic [3:0]           widx;
  logic [3:0]           rd_idx;
  logic [63:0]          length;
  logic                 pad_done;
  logic                 len_lo;
  logic                 tail;
  logic                 final_blk;
  logic [1:0]           oidx;
  logic                 in_acc;
  logic                 out_acc;
  logic [2:0]           count_eff;
  logic [31:0]          in_word;
  logic [31:0]          pad_word;
  logic                 wr_en;
  logic [31:0]          wr_word;
  logic                 start_cmp;

  assign in_acc  = item_valid && item_ready;
  assign out_acc = result_valid && result_ready;

  // Short counts apply only to the last word; anything above four saturates.
  always_comb begin
    if (!item.last_item || item.byte_count > md5_pkg::FULL_COUNT) begin
      count_eff = md5_pkg::FULL_COUNT;
    end else begin
      count_eff = item.byte_count;
    end
    case (count_eff)
      3'd0:    in_word = {24'h0, md5_pkg::PAD_BYTE};
      3'd1:    in_word = {16'h0, md5_pkg::PAD_BYTE, item.data_word[7:0]};
      3'd2:    in_word = {8'h0, md5_pkg::PAD_BYTE, item.data_word[15:0]};
      3'd3:    in_word = {md5_pkg::PAD_BYTE, item.data_word[23:0]};
      default: in_word = item.data_word;
    endcase
  end

  // Padding words: marker, zeros, then the bit length in the last two words.
  always_comb begin
    if (!pad_done) begin
      pad_word = {24'h0, md5_pkg::PAD_BYTE};
    end else if (widx == md5_pkg::LEN_LO_WORD) begin
      pad_word = length[31:0];
    end else if (widx == md5_pkg::LAST_WORD_IDX && len_lo) begin
      pad_word = length[63:32];
    end else begin
      pad_word = 32'h0;
    end
  end

  assign wr_en     = (state == md5_pkg::ST_IDLE && in_acc) || state == md5_pkg::ST_PAD;
  assign wr_word   = (state == md5_pkg::ST_PAD) ? pad_word : in_word;
  assign start_cmp = wr_en && widx == md5_pkg::LAST_WORD_IDX;

  // Block buffer.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk[widx] <= wr_word;
    end
  end

  md5_compress u_compress (
    .clk      (clk),
    .rst      (rst),
    .start    (start_cmp),
    .chain_in (chain),
    .m_word   (blk[rd_idx]),
    .rd_idx   (rd_idx),
    .stat     (cmp_stat),
    .result   (cmp_result)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      md5_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (widx == md5_pkg::LAST_WORD_IDX) begin
            state_next = md5_pkg::ST_COMP;
          end else if (item.last_item) begin
            state_next = md5_pkg::ST_PAD;
          end
        end
      end
      md5_pkg::ST_PAD: begin
        if (widx == md5_pkg::LAST_WORD_IDX) begin
          state_next = md5_pkg::ST_COMP;
        end
      end
      md5_pkg::ST_COMP: begin
        if (cmp_stat.done) begin
          if (final_blk) begin
            state_next = md5_pkg::ST_OUT;
          end else if (tail) begin
            state_next = md5_pkg::ST_PAD;
          end else begin
            state_next = md5_pkg::ST_IDLE;
          end
        end
      end
      md5_pkg::ST_OUT: begin
        if (out_acc && oidx == md5_pkg::LAST_DIGEST) begin
          state_next = md5_pkg::ST_IDLE;
        end
      end
      default: state_next = md5_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    item_ready         = (state == md5_pkg::ST_IDLE);
    result_valid       = (state == md5_pkg::ST_OUT);
    result.digest_word = chain[oidx];
    result.word_index  = oidx;
    result.last_word   = (oidx == md5_pkg::LAST_DIGEST);
  end

  // Sequencer, chain, length and fill registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= md5_pkg::ST_IDLE;
      chain     <= {md5_pkg::IV_D, md5_pkg::IV_C, md5_pkg::IV_B, md5_pkg::IV_A};
      widx      <= 4'd0;
      length    <= 64'd0;
      pad_done  <= 1'b0;
      len_lo    <= 1'b0;
      tail      <= 1'b0;
      final_blk <= 1'b0;
      oidx      <= 2'd0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        widx <= widx + 4'd1;
      end
      if (start_cmp) begin
        final_blk <= (state == md5_pkg::ST_PAD) && pad_done && len_lo;
      end
      // Word taken from the input side.
      if (state == md5_pkg::ST_IDLE && in_acc) begin
        length   <= length + {58'd0, count_eff, 3'd0};
        tail     <= item.last_item;
        pad_done <= (count_eff != md5_pkg::FULL_COUNT);
        len_lo   <= 1'b0;
      end
      // Padding progress.
      if (state == md5_pkg::ST_PAD) begin
        if (!pad_done) begin
          pad_done <= 1'b1;
        end else if (widx == md5_pkg::LEN_LO_WORD) begin
          len_lo <= 1'b1;
        end
      end
      // Fold the finished block into the chain.
      if (state == md5_pkg::ST_COMP && cmp_stat.done) begin
        chain[0] <= chain[0] + cmp_result[0];
        chain[1] <= chain[1] + cmp_result[1];
        chain[2] <= chain[2] + cmp_result[2];
        chain[3] <= chain[3] + cmp_result[3];
      end
      // Digest transactions; the last one restores the initial values.
      if (out_acc) begin
        oidx <= oidx + 2'd1;
        if (oidx == md5_pkg::LAST_DIGEST) begin
          chain     <= {md5_pkg::IV_D, md5_pkg::IV_C, md5_pkg::IV_B, md5_pkg::IV_A};
          widx      <= 4'd0;
          length    <= 64'd0;
          pad_done  <= 1'b0;
          len_lo    <= 1'b0;
          tail      <= 1'b0;
          final_blk <= 1'b0;
        end
      end
    end
  end

  // The digest is only shown after a complete, fully padded block.
  assert property (@(posedge clk) disable iff (rst)
    (state == md5_pkg::ST_OUT) |-> (widx == 4'd0 && pad_done && len_lo && !cmp_stat.busy))
    else $error("digest shown before padding finished");

  // The final digest word returns the engine to its initial state.
  assert property (@(posedge clk) disable iff (rst)
    (out_acc && result.last_word) |=> (state == md5_pkg::ST_IDLE && length == 64'd0))
    else $error("engine not reinitialized after digest");

  // Waiting for compression only happens while the unit is working or finishing.
  assert property (@(posedge clk) disable iff (rst)
    (state == md5_pkg::ST_COMP) |-> (cmp_stat.busy || cmp_stat.done))
    else $error("waiting on an idle compression unit");

endmodule
